// ----- hdl/b64d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the alphabet lookup for the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        STATUS_DATA  = 2'd0,
        STATUS_END   = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_DECODING = 2'd0,
        MODE_ENDED    = 2'd1,
        MODE_ERROR    = 2'd2
    } run_mode_t;

    typedef enum logic [1:0] {
        LB_NONE       = 2'd0,
        LB_CR_PENDING = 2'd1,
        LB_CRLF_DONE  = 2'd2
    } line_break_t;

    // One unit of work for the back end: up to three bytes, then an optional
    // closing result (STATUS_DATA here means no closing result).
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  num_bytes;
        status_t     tail;
    } job_t;

    // Bit 6 set marks a character outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) r = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) r = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) r = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B) r = 7'd62;
        else if (c == 8'h2F) r = 7'd63;
        return r;
    endfunction

    // Left-align the sextets of a partial group in a 24-bit group value.
    function automatic logic [23:0] align_group(input logic [1:0] count,
                                                input logic [17:0] store);
        logic [23:0] r;
        case (count)
            2'd1:    r = {store[5:0], 18'd0};
            2'd2:    r = {store[11:0], 12'd0};
            2'd3:    r = {store, 6'd0};
            default: r = 24'd0;
        endcase
        return r;
    endfunction

    // Bytes left by a partial final group.
    function automatic logic [1:0] partial_bytes(input logic [1:0] count,
                                                 input logic pad_third);
        logic [1:0] r;
        case (count)
            2'd0:    r = 2'd0;
            2'd3:    r = pad_third ? 2'd1 : 2'd2;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/b64d_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks group and line-break state, and issues one job
// per character that causes any result.
// ----------------------------------------------------------------------------
module b64d_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     in_char,
    input  wire logic           is_final,
    output b64d_pkg::job_t      job,
    output logic                job_push
);
    import b64d_pkg::*;

    logic [1:0]  pos_reg,   pos_next;
    logic [17:0] store_reg, store_next;
    logic [1:0]  pad_reg,   pad_next;
    line_break_t lb_reg,    lb_next;
    run_mode_t   mode_reg,  mode_next;

    logic        decoding;
    logic        is_cr, is_lf, is_eq;
    logic [6:0]  lookup;
    logic [5:0]  sx;
    logic        alpha_ok;
    logic        ev_err, ev_cr, ev_lf, ev_sx, ev_full;
    logic [1:0]  pad_new;
    logic [17:0] store_new;
    logic [1:0]  fin_count;
    logic [17:0] fin_store;
    logic        fin_pad;

    always_comb
    begin
        decoding  = (mode_reg == MODE_DECODING);
        is_cr     = (in_char == CHAR_CR);
        is_lf     = (in_char == CHAR_LF);
        is_eq     = (in_char == CHAR_PAD);
        lookup    = sextet_of(in_char);
        alpha_ok  = !lookup[6];
        sx        = is_eq ? 6'd0 : lookup[5:0];

        ev_lf  = (lb_reg == LB_CR_PENDING) && is_lf;
        ev_err = ((lb_reg == LB_CR_PENDING) && !is_lf)
              || ((lb_reg != LB_CR_PENDING) && is_cr
                  && ((lb_reg == LB_CRLF_DONE) || is_final))
              || ((lb_reg != LB_CR_PENDING) && !is_cr && !is_eq && !alpha_ok);
        ev_cr   = (lb_reg != LB_CR_PENDING) && is_cr && !ev_err;
        ev_sx   = (lb_reg != LB_CR_PENDING) && !is_cr && (is_eq || alpha_ok);
        ev_full = ev_sx && (pos_reg == 2'd3);

        pad_new = pad_reg;
        if (is_eq && pos_reg == 2'd2) pad_new[0] = 1'b1;
        if (is_eq && pos_reg == 2'd3) pad_new[1] = 1'b1;
        store_new = {store_reg[11:0], sx};

        // group seen by a stream close: the current one on LF, the updated one
        // on a sextet
        if (ev_lf)
        begin
            fin_count = pos_reg;
            fin_store = store_reg;
            fin_pad   = pad_reg[0];
        end
        else
        begin
            fin_count = pos_reg + 2'd1;
            fin_store = store_new;
            fin_pad   = pad_new[0];
        end
    end

    // next state
    always_comb
    begin
        pos_next   = pos_reg;
        store_next = store_reg;
        pad_next   = pad_reg;
        lb_next    = lb_reg;
        mode_next  = mode_reg;
        if (!decoding)
        begin
            if (is_final)
            begin
                pos_next = 2'd0; store_next = 18'd0; pad_next = 2'd0;
                lb_next = LB_NONE; mode_next = MODE_DECODING;
            end
        end
        else if (ev_err)
        begin
            mode_next = MODE_ERROR;
        end
        else if (ev_cr)
        begin
            lb_next = LB_CR_PENDING;
        end
        else if (ev_lf)
        begin
            lb_next = LB_CRLF_DONE;
        end
        else if (ev_full)
        begin
            lb_next = LB_NONE;
            if (pad_new != 2'd0)
            begin
                mode_next = MODE_ENDED;
            end
            else
            begin
                pos_next = 2'd0; store_next = 18'd0; pad_next = 2'd0;
            end
        end
        else
        begin
            lb_next    = LB_NONE;
            pos_next   = pos_reg + 2'd1;
            store_next = store_new;
            pad_next   = pad_new;
        end
        // the final character always restarts the stream
        if (is_final)
        begin
            pos_next = 2'd0; store_next = 18'd0; pad_next = 2'd0;
            lb_next = LB_NONE; mode_next = MODE_DECODING;
        end
    end

    // job issued
    always_comb
    begin
        job.bytes     = 24'd0;
        job.num_bytes = 2'd0;
        job.tail      = STATUS_DATA;
        if (decoding)
        begin
            if (ev_err)
            begin
                job.tail = STATUS_ERROR;
            end
            else if (ev_full)
            begin
                job.bytes = {store_reg, sx};
                if (pad_new[0])      job.num_bytes = 2'd1;
                else if (pad_new[1]) job.num_bytes = 2'd2;
                else                 job.num_bytes = 2'd3;
                if (pad_new != 2'd0 || is_final) job.tail = STATUS_END;
            end
            else if ((ev_lf || ev_sx) && is_final)
            begin
                job.bytes     = align_group(fin_count, fin_store);
                job.num_bytes = partial_bytes(fin_count, fin_pad);
                job.tail      = STATUS_END;
            end
        end
        job_push = accept && (job.num_bytes != 2'd0 || job.tail != STATUS_DATA);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            store_reg <= 18'd0;
            pad_reg   <= 2'd0;
            lb_reg    <= LB_NONE;
            mode_reg  <= MODE_DECODING;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            store_reg <= store_next;
            pad_reg   <= pad_next;
            lb_reg    <= lb_next;
            mode_reg  <= mode_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/b64d_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire b64d_pkg::job_t push_job,
    input  wire logic           pop,
    output b64d_pkg::job_t      head,
    output logic                empty,
    output logic                full
);
    import b64d_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg,  count_next;

    always_comb
    begin
        empty = (count_reg == '0);
        full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
        head  = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? PTR_W'((wr_ptr_reg + 1'b1) % QUEUE_DEPTH) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'((rd_ptr_reg + 1'b1) % QUEUE_DEPTH) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/b64d_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back
// Expands the head job into result words, one per cycle while the receiver
// is ready, through an output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire b64d_pkg::job_t head,
    input  wire logic           empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic [1:0]          status,
    output logic                last_of_run
);
    import b64d_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    status_t    status_reg, status_next;
    logic       last_reg, last_next;

    logic       load;
    logic [2:0] total;
    logic       is_last;

    always_comb
    begin
        load    = !empty && (!out_valid_reg || out_ready);
        total   = {1'b0, head.num_bytes} + ((head.tail != STATUS_DATA) ? 3'd1 : 3'd0);
        is_last = ({1'b0, idx_reg} == total - 3'd1);
        pop     = load && is_last;

        if (idx_reg < head.num_bytes)
        begin
            case (idx_reg)
                2'd0:    out_byte_next = head.bytes[23:16];
                2'd1:    out_byte_next = head.bytes[15:8];
                default: out_byte_next = head.bytes[7:0];
            endcase
            status_next = STATUS_DATA;
        end
        else
        begin
            out_byte_next = 8'd0;
            status_next   = head.tail;
        end
        last_next = is_last;

        idx_next = idx_reg;
        if (load)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= out_byte_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

endmodule
`default_nettype wire

// ----- hdl/base64_stream_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 text decoder, one character per word in, one result per word out.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | in_char[7:0], is_final
//   out     | out_valid / out_ready| out_byte[7:0], status[1:0], last_of_run
//
// A character is taken every cycle while the two-entry job queue has room.
// Each character yields zero to four result words; the back end sends one
// result word per cycle while out_ready is high, so a full group gives up to
// three data words, plus an end word when it also closes the stream.
// Each job is registered in the queue, then its words in the output register.
// Reset clears all decoding state, the queue and the output valid flag.
// Either side may stall; the queue decouples them.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_char,
    input  wire logic       is_final,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      status,
    output logic            last_of_run
);
    import b64d_pkg::*;

    job_t job;
    job_t head;
    logic job_push;
    logic q_empty;
    logic q_full;
    logic q_pop;
    logic accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_char  (in_char),
        .is_final (is_final),
        .job      (job),
        .job_push (job_push)
    );

    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule
`default_nettype wire

// ----- tb/base64_stream_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_test
// Self-checking bench for the Base64 stream decoder. A short stimulus table
// covers alphabet extremes, padding, line breaks and every parse error. It is
// followed by random streams, most of them well formed. A local decoder model
// predicts untyped rows and streams, and both handshakes stall at random.
// ----------------------------------------------------------------------------
module base64_stream_decoder_test;

    import b64d_pkg::*;

    localparam int RANDOM_ITEMS  = 90;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PRESSURE_AT   = 24;
    localparam int PRESSURE_HOLD = 300;
    localparam int DIR_ROWS      = 28;

    typedef struct packed {
        logic [7:0] data;
        status_t    stat;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_char_t;

    // typed = 1: the expected word (or its absence) is written in the row
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        logic       has_word;
        logic [7:0] wbyte;
        status_t    wstat;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_char = 8'h00;
    logic       is_final = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    base64_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .is_final    (is_final),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{"A",      1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{"A",      1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{"A",      1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{"A",      1'b0, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{"/",      1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{"/",      1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{"/",      1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{"/",      1'b1, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{8'h00,    1'b0, 1'b1, 1'b1, 8'h00, STATUS_ERROR},
        '{"A",      1'b1, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_CR,  1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{"A",      1'b0, 1'b1, 1'b1, 8'h00, STATUS_ERROR},
        '{8'hFF,    1'b1, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_CR,  1'b1, 1'b1, 1'b1, 8'h00, STATUS_ERROR},
        '{CHAR_CR,  1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_LF,  1'b0, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_CR,  1'b0, 1'b1, 1'b1, 8'h00, STATUS_ERROR},
        '{CHAR_PAD, 1'b1, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_LF,  1'b1, 1'b1, 1'b1, 8'h00, STATUS_ERROR},
        '{"Q",      1'b0, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{"Q",      1'b0, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_PAD, 1'b0, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_PAD, 1'b0, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{"Z",      1'b1, 1'b1, 1'b0, 8'h00, STATUS_DATA},
        '{"Q",      1'b0, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{"Q",      1'b0, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_CR,  1'b0, 1'b0, 1'b0, 8'h00, STATUS_DATA},
        '{CHAR_LF,  1'b1, 1'b0, 1'b0, 8'h00, STATUS_DATA}
    };

    // decoder model state
    logic [1:0]  grp_pos = 2'd0;
    logic [17:0] sextets = 18'd0;
    logic [1:0]  pads = 2'd0;
    line_break_t lb_phase = LB_NONE;
    run_mode_t   mode = MODE_DECODING;

    out_word_t   step_words[$];
    out_word_t   expected_words[$];
    text_char_t  text_q[$];

    int  fail_count = 0;
    int  words_seen = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    int  ready_left = 0;
    bit  pressure_done = 1'b0;
    bit  no_idle = 1'b0;

    function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
        if (ch >= 8'h41 && ch <= 8'h5A) return 7'(ch - 8'h41);
        if (ch >= 8'h61 && ch <= 8'h7A) return 7'(ch - 8'h47);
        if (ch >= 8'h30 && ch <= 8'h39) return 7'(ch + 8'h04);
        if (ch == 8'h2B) return 7'd62;
        if (ch == 8'h2F) return 7'd63;
        return 7'h40;
    endfunction

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26) return 8'h41 + w;
        if (w < 8'd52) return 8'h47 + w;
        if (w < 8'd62) return w - 8'h04;
        if (w == 8'd62) return 8'h2B;
        return 8'h2F;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic clear_model();
        grp_pos = 2'd0;
        sextets = 18'd0;
        pads = 2'd0;
        lb_phase = LB_NONE;
        mode = MODE_DECODING;
    endtask

    task automatic put_word(input logic [7:0] data, input status_t stat);
        step_words.push_back({data, stat, 1'b0});
    endtask

    task automatic put_group(input int count, input logic [23:0] word);
        put_word(word[23:16], STATUS_DATA);
        if (count >= 3 && !pads[0])
        begin
            put_word(word[15:8], STATUS_DATA);
            if (count == 4 && !pads[1])
                put_word(word[7:0], STATUS_DATA);
        end
    endtask

    // flush a partial group, then end the stream
    task automatic close_stream();
        int cnt;
        logic [23:0] w;
        cnt = grp_pos;
        if (cnt != 0)
        begin
            w = 24'(sextets) << (6 * (4 - cnt));
            put_group(cnt, w);
        end
        put_word(8'h00, STATUS_END);
        clear_model();
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic fin);
        logic err;
        logic [6:0] v;
        int pos;
        step_words.delete();
        err = 1'b0;
        if (mode != MODE_DECODING)
        begin
            if (fin)
                clear_model();
        end
        else
        begin
            if (lb_phase == LB_CR_PENDING)
            begin
                if (ch == CHAR_LF)
                begin
                    lb_phase = LB_CRLF_DONE;
                    if (fin)
                        close_stream();
                end
                else
                    err = 1'b1;
            end
            else if (ch == CHAR_CR)
            begin
                if (lb_phase == LB_CRLF_DONE || fin)
                    err = 1'b1;
                else
                    lb_phase = LB_CR_PENDING;
            end
            else
            begin
                pos = grp_pos;
                if (ch == CHAR_PAD)
                begin
                    v = 7'd0;
                    if (pos == 2) pads[0] = 1'b1;
                    if (pos == 3) pads[1] = 1'b1;
                end
                else
                    v = char_to_sextet(ch);
                if (v[6])
                    err = 1'b1;
                else
                begin
                    lb_phase = LB_NONE;
                    if (pos == 3)
                    begin
                        put_group(4, {sextets, v[5:0]});
                        if (pads != 2'd0)
                        begin
                            put_word(8'h00, STATUS_END);
                            if (fin)
                                clear_model();
                            else
                                mode = MODE_ENDED;
                        end
                        else
                        begin
                            grp_pos = 2'd0;
                            sextets = 18'd0;
                            pads = 2'd0;
                            if (fin)
                                close_stream();
                        end
                    end
                    else
                    begin
                        sextets = {sextets[11:0], v[5:0]};
                        grp_pos = 2'(pos + 1);
                        if (fin)
                            close_stream();
                    end
                end
            end
            if (err)
            begin
                put_word(8'h00, STATUS_ERROR);
                if (fin)
                    clear_model();
                else
                    mode = MODE_ERROR;
            end
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
    endtask

    // offer one word, hold it until taken, then log what it should cause
    task automatic send_char(input logic [7:0] ch, input logic fin, input logic typed,
                             input logic has_word, input logic [7:0] wbyte,
                             input status_t wstat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= ch;
        is_final <= fin;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        decode_char(ch, fin);
        if (typed)
        begin
            if (has_word)
                expected_words.push_back({wbyte, wstat, 1'b1});
        end
        else
        begin
            foreach (step_words[k])
                expected_words.push_back(step_words[k]);
        end
    endtask

    // one text character, with an occasional CR LF before it
    task automatic add_text_char();
        int r;
        if ($urandom_range(0, 99) < 10)
        begin
            text_q.push_back({CHAR_CR, 1'b0});
            text_q.push_back({CHAR_LF, 1'b0});
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            text_q.push_back({8'($urandom_range(0, 255)), 1'b0});
        else if (r < 7)
            text_q.push_back({CHAR_PAD, 1'b0});
        else
            text_q.push_back({sextet_to_char(6'($urandom_range(0, 63))), 1'b0});
    endtask

    task automatic build_stream();
        int groups;
        int kind;
        int n;
        no_idle = ($urandom_range(0, 3) == 0);
        groups = $urandom_range(0, 3);
        kind = $urandom_range(0, 7);
        if (kind == 0 && groups == 0)
            groups = 1;
        repeat (groups * 4) add_text_char();
        case (kind)
            1:
            begin
                repeat (2) add_text_char();
                text_q.push_back({CHAR_PAD, 1'b0});
                text_q.push_back({CHAR_PAD, 1'b0});
            end
            2:
            begin
                repeat (3) add_text_char();
                text_q.push_back({CHAR_PAD, 1'b0});
            end
            3:
            begin
                n = $urandom_range(1, 3);
                repeat (n) add_text_char();
            end
            4:
            begin
                text_q.push_back({CHAR_CR, 1'b0});
                text_q.push_back({CHAR_LF, 1'b0});
            end
            5:
            begin
                n = $urandom_range(1, 4);
                repeat (n) text_q.push_back({8'($urandom_range(0, 255)), 1'b0});
            end
            6:
            begin
                text_q.push_back({CHAR_CR, 1'b0});
                text_q.push_back({8'($urandom_range(0, 255)), 1'b0});
            end
            7:
            begin
                // padded end, then trailing text that must be dropped
                repeat (3) add_text_char();
                text_q.push_back({CHAR_PAD, 1'b0});
                n = $urandom_range(1, 3);
                repeat (n) text_q.push_back({8'($urandom_range(0, 255)), 1'b0});
            end
            default:
            begin
            end
        endcase
        if (text_q.size() == 0)
            text_q.push_back({8'($urandom_range(0, 255)), 1'b0});
        text_q[text_q.size() - 1].fin = 1'b1;
    endtask

    // result check and receiver stalls
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (out_valid === 1'b1 && out_ready)
        begin
            words_seen++;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: out_byte %h status %0d last_of_run %b",
                       out_byte, status, last_of_run);
                fail_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (out_byte !== exp_w.data)
                begin
                    $error("out_byte: expected %h, got %h", exp_w.data, out_byte);
                    fail_count++;
                end
                if (status !== exp_w.stat)
                begin
                    $error("status: expected %0d, got %0d", exp_w.stat, status);
                    fail_count++;
                end
                if (last_of_run !== exp_w.last)
                begin
                    $error("last_of_run: expected %b, got %b", exp_w.last, last_of_run);
                    fail_count++;
                end
            end
        end
        if (rst_n)
        begin
            if (!pressure_done && words_seen >= PRESSURE_AT)
            begin
                // hold off long enough for the input side to back up
                pressure_done = 1'b1;
                hold_left = PRESSURE_HOLD;
                ready_left = 0;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (ready_left > 0)
            begin
                ready_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                ready_left = $urandom_range(1, 24);
                hold_left = pick_gap();
                if (hold_left > 0)
                begin
                    hold_left--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    ready_left--;
                    out_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int sent;
        text_char_t tc;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIR_ROWS; i++)
            send_char(dir_table[i].ch, dir_table[i].fin, dir_table[i].typed,
                      dir_table[i].has_word, dir_table[i].wbyte, dir_table[i].wstat);
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            build_stream();
            while (text_q.size() > 0)
            begin
                tc = text_q.pop_front();
                send_char(tc.ch, tc.fin, 1'b0, 1'b0, 8'h00, STATUS_DATA);
                sent++;
            end
        end
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
